// ----- hw/rtl/lcsp_pkg.sv -----
package lcsp_pkg;

    localparam int QDepth = 4;                      // power of two
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [1:0] CmdReset  = 2'd0;
    localparam logic [1:0] CmdColour = 2'd1;
    localparam logic [1:0] CmdEob    = 2'd2;
    localparam logic [1:0] CmdTx     = 2'd3;

    localparam logic [1:0] ModeMorph = 2'd0;
    localparam logic [1:0] ModeFixed = 2'd1;
    localparam logic [1:0] ModeBlink = 2'd2;

    localparam logic [7:0] ChZ     = 8'h7A;
    localparam logic [7:0] ChM     = 8'h6D;
    localparam logic [7:0] ChF     = 8'h66;
    localparam logic [7:0] ChB     = 8'h62;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChSpace = 8'h20;

    localparam logic [2:0] MorphLen = 3'd6;
    localparam logic [2:0] FlatLen  = 3'd3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ZONE1 = 4'b0010,
        PH_ZONE2 = 4'b0100,
        PH_COL   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        rst;
        logic        col;
        logic        eob;
        logic        tx;
    } t_flags;

    typedef struct packed {
        t_flags      flags;
        logic [15:0] block;
        logic [1:0]  mode;
        logic [31:0] zones;
        logic [23:0] nib;
    } t_rec;

    typedef struct packed {
        logic        all;
        logic        set;
        logic [4:0]  idx;
    } t_zone;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == ChSpace) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

    // decimal zone from up to two chars: spaces, optional sign, digits
    function automatic t_zone zone_decode(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic two);
        logic [6:0] v;
        logic       neg;
        t_zone      z;
        v   = 7'd0;
        neg = 1'b0;
        if (!two) begin
            if (is_digit(c0)) v = 7'(c0[3:0]);
        end else if (is_space(c0)) begin
            if (is_digit(c1)) v = 7'(c1[3:0]);
        end else if (c0 == ChPlus || c0 == ChMinus) begin
            neg = (c0 == ChMinus);
            if (is_digit(c1)) v = 7'(c1[3:0]);
        end else if (is_digit(c0)) begin
            if (is_digit(c1)) v = 7'(c0[3:0]) * 7'd10 + 7'(c1[3:0]);
            else              v = 7'(c0[3:0]);
        end
        z.all = (v == 7'd0);
        z.set = !neg && (v >= 7'd1) && (v <= 7'd32);
        z.idx = 5'(v - 7'd1);
        return z;
    endfunction

endpackage

// ----- hw/rtl/lighting_command_string_parser.sv -----
// A result passes the queue, the sequencer flag register and the output register.
// Throughput: one input word per cycle while full is low; the result side gives one
// word per cycle while popped, so an input with several results holds the output
// longer; a 4-entry queue between decoder and result sequencer absorbs the difference.
// Reset: synchronous, active low; parser state, queue and output return to empty/idle.
module lighting_command_string_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_ch,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_cmd,
    output logic [1:0]  o_mode,
    output logic [15:0] o_block,
    output logic [31:0] o_zones,
    output logic [3:0]  o_red_a,
    output logic [3:0]  o_green_a,
    output logic [3:0]  o_blue_a,
    output logic [3:0]  o_red_b,
    output logic [3:0]  o_green_b,
    output logic [3:0]  o_blue_b,
    output logic        o_final_res
);

    logic               accept;
    logic               rec_push;
    lcsp_pkg::t_rec     rec_in, rec_out;
    logic               q_vld, q_pop;

    assign accept = push && !full;

    lcsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_ch       (i_ch),
        .o_rec_push (rec_push),
        .o_rec      (rec_in)
    );

    lcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_rec   (rec_out)
    );

    lcsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_q_rec     (rec_out),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_cmd       (o_cmd),
        .o_mode      (o_mode),
        .o_block     (o_block),
        .o_zones     (o_zones),
        .o_red_a     (o_red_a),
        .o_green_a   (o_green_a),
        .o_blue_a    (o_blue_a),
        .o_red_b     (o_red_b),
        .o_green_b   (o_green_b),
        .o_blue_b    (o_blue_b),
        .o_final_res (o_final_res)
    );

endmodule

// ----- hw/rtl/lcsp_front.sv -----
module lcsp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [7:0]         i_ch,
    output logic               o_rec_push,
    output lcsp_pkg::t_rec     o_rec
);

    logic                  r_started,  n_started;
    logic                  r_grouping, n_grouping;
    logic [31:0]           r_mask,     n_mask;
    logic [15:0]           r_block,    n_block;
    lcsp_pkg::t_phase      r_phase,    n_phase;
    logic [2:0]            r_k,        n_k;
    logic [7:0]            r_zc,       n_zc;
    logic [23:0]           r_nib,      n_nib;
    logic [1:0]            r_mode,     n_mode;

    lcsp_pkg::t_rec        rec;
    lcsp_pkg::t_zone       zone;
    logic [7:0]            lc;
    logic [23:0]           nib_new;
    logic [2:0]            k_next;
    logic [2:0]            col_len;

    always_comb begin
        zone    = lcsp_pkg::zone_decode(r_zc, i_ch, 1'b1);
        lc      = (i_ch >= 8'h41 && i_ch <= 8'h5A) ? (i_ch | 8'h20) : i_ch;
        col_len = (r_mode == lcsp_pkg::ModeMorph) ? lcsp_pkg::MorphLen : lcsp_pkg::FlatLen;
        k_next  = r_k + 3'd1;
        nib_new = r_nib;
        for (int i = 0; i < 6; i++) begin
            if (r_k == 3'(i)) nib_new[(5 - i) * 4 +: 4] = lcsp_pkg::hex_val(i_ch);
        end
    end

    always_comb begin
        n_started  = r_started;
        n_grouping = r_grouping;
        n_mask     = r_mask;
        n_block    = r_block;
        n_phase    = r_phase;
        n_k        = r_k;
        n_zc       = r_zc;
        n_nib      = r_nib;
        n_mode     = r_mode;
        rec        = '0;
        rec.block  = r_block;
        rec.mode   = r_mode;
        rec.zones  = r_mask;
        rec.nib    = (i_op ? r_nib : nib_new)
                   & ((r_mode == lcsp_pkg::ModeMorph) ? 24'hFFFFFF : 24'hFFF000);

        if (i_accept) begin
            if (!r_started) begin
                rec.flags.rst = 1'b1;
                n_started     = 1'b1;
            end
            if (i_op) begin
                rec.flags.col = (r_phase == lcsp_pkg::PH_COL);
                rec.flags.eob = 1'b1;
                rec.flags.tx  = 1'b1;
                n_started     = 1'b0;
                n_grouping    = 1'b0;
                n_mask        = '0;
                n_block       = '0;
                n_phase       = lcsp_pkg::PH_IDLE;
                n_k           = '0;
                n_zc          = '0;
                n_nib         = '0;
                n_mode        = lcsp_pkg::ModeMorph;
            end else begin
                unique case (r_phase)
                    lcsp_pkg::PH_ZONE1: begin
                        n_zc    = i_ch;
                        n_phase = lcsp_pkg::PH_ZONE2;
                    end
                    lcsp_pkg::PH_ZONE2: begin
                        if (zone.all)      n_mask            = '1;
                        else if (zone.set) n_mask[zone.idx]  = 1'b1;
                        n_phase = lcsp_pkg::PH_IDLE;
                    end
                    lcsp_pkg::PH_COL: begin
                        n_nib = nib_new;
                        if (k_next >= col_len) begin
                            rec.flags.col = 1'b1;
                            n_phase       = lcsp_pkg::PH_IDLE;
                        end else begin
                            n_k = k_next;
                        end
                    end
                    lcsp_pkg::PH_IDLE: begin
                        if (lc == lcsp_pkg::ChZ) begin
                            if (!r_grouping) begin
                                n_grouping    = 1'b1;
                                n_mask        = '0;
                                rec.flags.eob = (r_block != 16'd0);
                                n_block       = r_block + 16'd1;
                            end
                            n_phase = lcsp_pkg::PH_ZONE1;
                        end else if (lc == lcsp_pkg::ChM || lc == lcsp_pkg::ChF
                                     || lc == lcsp_pkg::ChB) begin
                            n_grouping = 1'b0;
                            n_mode     = (lc == lcsp_pkg::ChM) ? lcsp_pkg::ModeMorph :
                                         (lc == lcsp_pkg::ChF) ? lcsp_pkg::ModeFixed :
                                                                  lcsp_pkg::ModeBlink;
                            n_nib      = '0;
                            n_k        = '0;
                            n_phase    = lcsp_pkg::PH_COL;
                        end else begin
                            n_grouping = 1'b0;
                        end
                    end
                    default: n_phase = lcsp_pkg::PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_grouping <= 1'b0;
            r_mask     <= '0;
            r_block    <= '0;
            r_phase    <= lcsp_pkg::PH_IDLE;
            r_k        <= '0;
            r_zc       <= '0;
            r_nib      <= '0;
            r_mode     <= lcsp_pkg::ModeMorph;
        end else begin
            r_started  <= n_started;
            r_grouping <= n_grouping;
            r_mask     <= n_mask;
            r_block    <= n_block;
            r_phase    <= n_phase;
            r_k        <= n_k;
            r_zc       <= n_zc;
            r_nib      <= n_nib;
            r_mode     <= n_mode;
        end
    end

    assign o_rec      = rec;
    assign o_rec_push = i_accept && (rec.flags != '0);

endmodule

// ----- hw/rtl/lcsp_queue.sv -----
module lcsp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcsp_pkg::t_rec     i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_vld,
    output lcsp_pkg::t_rec     o_rec
);

    lcsp_pkg::t_rec                 r_mem [lcsp_pkg::QDepth];
    logic [lcsp_pkg::QPtrW-1:0]     r_wp, r_rp;
    logic [lcsp_pkg::QCntW-1:0]     r_cnt, n_cnt;
    logic                           wr, rd;

    assign wr     = i_push && !o_full;
    assign rd     = i_pop && o_vld;
    assign o_full = (r_cnt == lcsp_pkg::QCntW'(lcsp_pkg::QDepth));
    assign o_vld  = (r_cnt != '0);
    assign o_rec  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd)      n_cnt = r_cnt + 1'b1;
        else if (rd && !wr) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/lcsp_back.sv -----
module lcsp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_vld,
    input  lcsp_pkg::t_rec     i_q_rec,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [1:0]         o_cmd,
    output logic [1:0]         o_mode,
    output logic [15:0]        o_block,
    output logic [31:0]        o_zones,
    output logic [3:0]         o_red_a,
    output logic [3:0]         o_green_a,
    output logic [3:0]         o_blue_a,
    output logic [3:0]         o_red_b,
    output logic [3:0]         o_green_b,
    output logic [3:0]         o_blue_b,
    output logic               o_final_res
);

    lcsp_pkg::t_flags   r_flags, n_flags;
    lcsp_pkg::t_rec     r_rec;
    logic               r_out_vld;
    logic [1:0]         r_cmd;
    logic [1:0]         r_mode;
    logic [15:0]        r_block;
    logic [31:0]        r_zones;
    logic [23:0]        r_nib;
    logic               r_final;

    lcsp_pkg::t_flags   pick, remain;
    logic [1:0]         cmd;
    logic               out_rdy, emit, load;

    always_comb begin
        pick = '0;
        cmd  = lcsp_pkg::CmdReset;
        if (r_flags.rst) begin
            pick.rst = 1'b1;
            cmd      = lcsp_pkg::CmdReset;
        end else if (r_flags.col) begin
            pick.col = 1'b1;
            cmd      = lcsp_pkg::CmdColour;
        end else if (r_flags.eob) begin
            pick.eob = 1'b1;
            cmd      = lcsp_pkg::CmdEob;
        end else if (r_flags.tx) begin
            pick.tx  = 1'b1;
            cmd      = lcsp_pkg::CmdTx;
        end
        remain  = r_flags & ~pick;
        out_rdy = !r_out_vld || i_pop;
        emit    = out_rdy && (r_flags != '0);
        load    = i_q_vld && ((r_flags == '0) || (emit && (remain == '0)));
        n_flags = load ? i_q_rec.flags : (emit ? remain : r_flags);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_flags <= n_flags;
            if (emit)       r_out_vld <= 1'b1;
            else if (i_pop) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_rec <= i_q_rec;
        if (emit) begin
            r_cmd   <= cmd;
            r_block <= r_rec.block;
            r_final <= (remain == '0);
            r_mode  <= pick.col ? r_rec.mode  : lcsp_pkg::ModeMorph;
            r_zones <= pick.col ? r_rec.zones : '0;
            r_nib   <= pick.col ? r_rec.nib   : '0;
        end
    end

    assign o_q_pop     = load;
    assign o_empty     = !r_out_vld;
    assign o_cmd       = r_cmd;
    assign o_mode      = r_mode;
    assign o_block     = r_block;
    assign o_zones     = r_zones;
    assign o_red_a     = r_nib[23:20];
    assign o_green_a   = r_nib[19:16];
    assign o_blue_a    = r_nib[15:12];
    assign o_red_b     = r_nib[11:8];
    assign o_green_b   = r_nib[7:4];
    assign o_blue_b    = r_nib[3:0];
    assign o_final_res = r_final;

endmodule

// ----- hw/rtl/lcsp_checker.sv -----
module lcsp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_ch,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  o_cmd,
    input  logic [1:0]  o_mode,
    input  logic [15:0] o_block,
    input  logic [31:0] o_zones,
    input  logic [3:0]  o_red_a,
    input  logic [3:0]  o_green_a,
    input  logic [3:0]  o_blue_a,
    input  logic [3:0]  o_red_b,
    input  logic [3:0]  o_green_b,
    input  logic [3:0]  o_blue_b,
    input  logic        o_final_res
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_cmd) && $stable(o_block)
                           && $stable(o_zones) && $stable(o_final_res))
        else $error("result word changed while stalled");

    a_tx_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_cmd == lcsp_pkg::CmdTx |-> o_final_res)
        else $error("transmit is not the last word of its input");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_cmd != lcsp_pkg::CmdColour |-> o_zones == '0
            && o_mode == lcsp_pkg::ModeMorph && o_red_a == '0 && o_blue_b == '0)
        else $error("non-colour word carries colour payload");

    a_reset_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_cmd == lcsp_pkg::CmdReset |-> o_block == '0)
        else $error("reset word with nonzero block");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_cmd == lcsp_pkg::CmdColour |-> (o_mode == lcsp_pkg::ModeMorph)
            || ((o_mode == lcsp_pkg::ModeFixed || o_mode == lcsp_pkg::ModeBlink)
                && o_red_b == '0 && o_green_b == '0 && o_blue_b == '0))
        else $error("illegal colour mode or stray morph target");

endmodule

bind lighting_command_string_parser lcsp_checker u_lcsp_checker (.*);
